FILE: rtl/core/bfsd_pkg.sv
// shared constants and types of the seeded djb2 bloom filter
package bfsd_pkg;

    localparam int MAX_BITS   = 65536;
    localparam int MAX_HASHES = 16;

    localparam logic [31:0] HASH_START = 32'd5381;
    localparam int          HASH_SHIFT = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int BC_W       = 17;
    localparam int HC_W       = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = CFG_IDX_W'(1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam int M_W   = $clog2(MAX_BITS + 1);
    localparam int K_W   = $clog2(MAX_HASHES + 1);
    localparam int P_W   = $clog2(MAX_BITS);
    localparam int ROW_W = 8;
    localparam int SEL_W = $clog2(ROW_W);
    localparam int ROWS  = (MAX_BITS + ROW_W - 1) / ROW_W;
    localparam int A_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = 32 / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;

    localparam logic [M_W-1:0] MOD_RESET =
        M_W'((MAX_BITS < 65536) ? MAX_BITS : 65536);
    localparam logic [K_W-1:0] PROBE_RESET =
        K_W'((MAX_HASHES < 4) ? MAX_HASHES : 4);

    typedef struct packed {
        logic        kind;
        logic [31:0] acc;
        logic [31:0] pow;
    } job_t;

    typedef struct packed {
        logic [M_W-1:0] modulus;
        logic [K_W-1:0] probes;
    } cfg_t;

endpackage

FILE: rtl/core/bfsd_ram.sv
// generic single-write, single-read ram with registered read data
module bfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bfsd_front.sv
// key byte front end: running djb2 accumulator and power of 33
module bfsd_front import bfsd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       kind,
    input  logic [7:0] key_byte,
    input  logic       last,
    output logic       job_push,
    output job_t       job
);

    logic [31:0] acc_reg, acc_next;
    logic [31:0] pow_reg, pow_next;
    logic [31:0] c_ext;

    always_comb
    begin
        c_ext    = {{24{key_byte[7]}}, key_byte};
        acc_next = acc_reg;
        pow_next = pow_reg;
        if (key_byte != 8'd0)
        begin
            acc_next = (acc_reg << HASH_SHIFT) + acc_reg + c_ext;
            pow_next = (pow_reg << HASH_SHIFT) + pow_reg;
        end
    end

    assign job_push = accept & last;
    assign job.kind = kind;
    assign job.acc  = acc_next;
    assign job.pow  = pow_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= HASH_START;
            pow_reg <= 32'd1;
        end
        else if (accept)
        begin
            if (last)
            begin
                acc_reg <= HASH_START;
                pow_reg <= 32'd1;
            end
            else
            begin
                acc_reg <= acc_next;
                pow_reg <= pow_next;
            end
        end
    end

endmodule

FILE: rtl/core/bfsd_queue.sv
// short job queue between the hash front end and the probe engine
module bfsd_queue import bfsd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t             slot_reg [JQ_DEPTH];
    logic [JQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [JQ_AW:0]   cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (JQ_AW + 1)'(JQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = slot_reg[rd_ptr_reg];

    function automatic logic [JQ_AW-1:0] wrap_inc(input logic [JQ_AW-1:0] p);
        return (p == JQ_AW'(JQ_DEPTH - 1)) ? '0 : p + JQ_AW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (JQ_AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - (JQ_AW + 1)'(1);
            end
        end
    end

endmodule

FILE: rtl/core/bfsd_back.sv
// probe engine: store clear, serial modulo, bit store access and result slot
module bfsd_back import bfsd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  job_t job,
    input  logic job_empty,
    output logic job_pop,
    output logic clear_busy,
    output logic empty,
    input  logic pop,
    output logic present
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [A_W-1:0]       clr_addr_reg;
    logic                 kind_reg;
    logic [31:0]          h_reg;
    logic [31:0]          pow_reg;
    logic [31:0]          work_reg;
    logic [M_W-1:0]       rem_reg;
    logic [MOD_CNT_W-1:0] step_reg;
    logic [K_W-1:0]       probe_reg;
    logic                 found_reg;
    logic [A_W-1:0]       row_reg;
    logic [SEL_W-1:0]     sel_reg;
    logic                 out_valid_reg;
    logic                 present_reg;

    logic [M_W-1:0]   rem_step;
    logic [P_W-1:0]   pos_c;
    logic [31:0]      h_nxt;
    logic [K_W-1:0]   probe_inc;
    logic             ram_we;
    logic [A_W-1:0]   ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic             bit_c;
    logic             result_load;

    // four restoring steps of the remainder per cycle
    always_comb
    begin
        logic [M_W-1:0] t;
        logic [M_W:0]   w;
        t = rem_reg;
        for (int j = 0; j < MOD_BITS; j++)
        begin
            w = {t, work_reg[31-j]};
            if (w >= {1'b0, cfg.modulus})
            begin
                w = w - {1'b0, cfg.modulus};
            end
            t = w[M_W-1:0];
        end
        rem_step = t;
    end

    assign pos_c     = rem_step[P_W-1:0];
    assign h_nxt     = h_reg + pow_reg;
    assign probe_inc = probe_reg + K_W'(1);
    assign bit_c     = ram_rdata[sel_reg];

    assign ram_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_CHECK && kind_reg == KIND_INSERT);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : row_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 :
                       (ram_rdata | (ROW_W'(1) << sel_reg));

    bfsd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (row_reg),
        .rdata (ram_rdata)
    );

    assign job_pop     = (state_reg == S_IDLE) && !job_empty;
    assign clear_busy  = (state_reg == S_CLEAR);
    assign empty       = ~out_valid_reg;
    assign present     = present_reg;
    assign result_load = (state_reg == S_FINISH) && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            present_reg   <= 1'b0;
            kind_reg      <= KIND_INSERT;
            h_reg         <= '0;
            pow_reg       <= '0;
            work_reg      <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            probe_reg     <= '0;
            found_reg     <= 1'b1;
            row_reg       <= '0;
            sel_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg && !result_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + A_W'(1);
                    if (clr_addr_reg == A_W'(ROWS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        kind_reg  <= job.kind;
                        h_reg     <= job.acc;
                        pow_reg   <= job.pow;
                        work_reg  <= job.acc;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        probe_reg <= '0;
                        found_reg <= 1'b1;
                        state_reg <= (cfg.probes == '0) ? S_FINISH : S_MOD;
                    end
                end
                S_MOD:
                begin
                    rem_reg  <= rem_step;
                    work_reg <= work_reg << MOD_BITS;
                    step_reg <= step_reg + MOD_CNT_W'(1);
                    if (step_reg == MOD_CNT_W'(MOD_CYCLES - 1))
                    begin
                        row_reg   <= A_W'(pos_c >> SEL_W);
                        sel_reg   <= pos_c[SEL_W-1:0];
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (kind_reg == KIND_QUERY && !bit_c)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_FINISH;
                    end
                    else if (probe_inc == cfg.probes)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        probe_reg <= probe_inc;
                        h_reg     <= h_nxt;
                        work_reg  <= h_nxt;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_MOD;
                    end
                end
                S_FINISH:
                begin
                    if (result_load)
                    begin
                        out_valid_reg <= 1'b1;
                        present_reg   <= (kind_reg == KIND_QUERY) & found_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/bloom_filter_seeded_djb2.sv
// top level of the seeded djb2 bloom filter
// Key bytes are taken one per cycle whenever full is low; the hash front end
// needs a single shift-add per byte. The byte flagged last hands the key to
// the probe engine through a two-deep job queue, and each probe then runs the
// 4-bit-per-cycle serial modulo, a registered read of the bit store and a
// check or read-modify-write; a query stops at its first probe that finds a
// clear bit. Bytes keep streaming while the engine works, until the queue
// fills. After reset the bit store is cleared one 8-bit row per cycle, all
// 8192 rows, and full stays high until the clear is done; configuration
// writes are taken throughout.
module bloom_filter_seeded_djb2 import bfsd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  kind,
    input  logic [7:0]            key_byte,
    input  logic                  last,
    output logic                  empty,
    input  logic                  pop,
    output logic                  present,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    job_t front_job, head_job;
    logic job_push, job_pop, q_full, q_empty, clear_busy, accept;
    logic [BC_W-1:0] bc_val;
    logic [HC_W-1:0] hc_val;

    assign full   = q_full | clear_busy;
    assign accept = push & ~full;
    assign bc_val = cfg_data[BC_W-1:0];
    assign hc_val = cfg_data[HC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus <= MOD_RESET;
            cfg_reg.probes  <= PROBE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BIT_COUNT)
            begin
                if (bc_val == '0)
                begin
                    cfg_reg.modulus <= M_W'(1);
                end
                else if (32'(bc_val) > 32'(MAX_BITS))
                begin
                    cfg_reg.modulus <= M_W'(MAX_BITS);
                end
                else
                begin
                    cfg_reg.modulus <= M_W'(bc_val);
                end
            end
            else if (cfg_index == REG_HASH_COUNT)
            begin
                if (32'(hc_val) > 32'(MAX_HASHES))
                begin
                    cfg_reg.probes <= K_W'(MAX_HASHES);
                end
                else
                begin
                    cfg_reg.probes <= K_W'(hc_val);
                end
            end
        end
    end

    bfsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind),
        .key_byte (key_byte),
        .last     (last),
        .job_push (job_push),
        .job      (front_job)
    );

    bfsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .pop      (job_pop),
        .head     (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    bfsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job        (head_job),
        .job_empty  (q_empty),
        .job_pop    (job_pop),
        .clear_busy (clear_busy),
        .empty      (empty),
        .pop        (pop),
        .present    (present)
    );

endmodule

FILE: rtl/core/bfsd_checker.sv
// port-level checks of the bloom filter, bound to the top level
module bfsd_checker (
    input logic clk,
    input logic rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic present
);

    // a waiting result beat is not withdrawn
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat withdrawn before pop");

    // a waiting result beat keeps its value
    a_present_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(present))
        else $error("present changed while result waiting");

    // store clear keeps input closed right after reset
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> full)
        else $error("input open before store clear finished");

    // no result is waiting right after reset
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

endmodule

bind bloom_filter_seeded_djb2 bfsd_checker u_bfsd_checker (.*);
